@@ hw/rtl/ldc_pkg.sv @@
// shared types and constants for the lens undistortion coordinate map
`default_nettype none

package ldc_pkg;

    // frame size in pixels
    localparam int FRAME_COLS = 752;
    localparam int FRAME_ROWS = 480;

    // field widths
    localparam int PIX_W  = 11;
    localparam int Q12_W  = 24;
    localparam int COEF_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NORM_W = 26;    // normalized coordinate, q.24 in [-2, 2)

    // divider: one quotient bit per stage
    localparam int DIV_STEPS = NORM_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int POLY_LAT  = 11;
    localparam int TOTAL_LAT = DIV_LAT + POLY_LAT;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X = 3'd0,
        CFG_FOCAL_Y = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_RADIAL_K1 = 3'd4,
        CFG_RADIAL_K2 = 3'd5,
        CFG_TANG_P1 = 3'd6,
        CFG_TANG_P2 = 3'd7
    } t_cfg_idx;

    // reset values
    localparam logic [Q12_W-1:0] RST_FOCAL_X  = 24'd1878647;
    localparam logic [Q12_W-1:0] RST_FOCAL_Y  = 24'd1873084;
    localparam logic [Q12_W-1:0] RST_CENTER_X = 24'd1504113;
    localparam logic [Q12_W-1:0] RST_CENTER_Y = 24'd1017344;
    localparam logic signed [COEF_W-1:0] RST_K1 = -32'sd304307141;
    localparam logic signed [COEF_W-1:0] RST_K2 = 32'sd79412947;
    localparam logic signed [COEF_W-1:0] RST_P1 = 32'sd207865;
    localparam logic signed [COEF_W-1:0] RST_P2 = 32'sd18918;

    // live configuration handed to the datapath
    typedef struct packed {
        logic [Q12_W-1:0]         focal_x;
        logic [Q12_W-1:0]         focal_y;
        logic [Q12_W-1:0]         center_x;
        logic [Q12_W-1:0]         center_y;
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] p1;
        logic signed [COEF_W-1:0] p2;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/lens_undistort_coord_map.sv @@
// top level of the lens undistortion coordinate map
//
// channel   dir  tdata (low bit up)            tuser
// s_axis    in   out_col[10:0] out_row[21:11]  -
// m_axis    out  src_col[10:0] src_row[21:11]  in_frame
// cfg       in   index selects register, data 32 bits, no read-back
//
// one transfer per clock while the sink keeps up; data runs through the
// one-bit-per-stage dividers for x and y, then the polynomial pipeline
// the whole pipeline moves as one: it halts only while a result waits
// in the output register and the sink is not ready
// synchronous active-low reset clears the valid bits and loads the configuration registers with their reset values
`default_nettype none

module lens_undistort_coord_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // out_col, out_row, zero pad
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // src_col, src_row, zero pad
    output logic             o_m_axis_tuser,   // in_frame
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import ldc_pkg::*;

    t_cfg r_cfg;
    logic [TOTAL_LAT-1:0] r_vld;
    logic en;
    logic signed [NORM_W-1:0] x, y;
    logic [PIX_W-1:0] col, row;
    logic in_frame;

    // advance unless the output register holds a result not yet taken
    assign en = !r_vld[TOTAL_LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[TOTAL_LAT-1];
    assign o_m_axis_tdata  = {2'b00, row, col};
    assign o_m_axis_tuser  = in_frame;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= RST_FOCAL_X;
            r_cfg.focal_y  <= RST_FOCAL_Y;
            r_cfg.center_x <= RST_CENTER_X;
            r_cfg.center_y <= RST_CENTER_Y;
            r_cfg.k1 <= RST_K1;
            r_cfg.k2 <= RST_K2;
            r_cfg.p1 <= RST_P1;
            r_cfg.p2 <= RST_P2;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:   r_cfg.focal_x  <= i_cfg_data[Q12_W-1:0];
                CFG_FOCAL_Y:   r_cfg.focal_y  <= i_cfg_data[Q12_W-1:0];
                CFG_CENTER_X:  r_cfg.center_x <= i_cfg_data[Q12_W-1:0];
                CFG_CENTER_Y:  r_cfg.center_y <= i_cfg_data[Q12_W-1:0];
                CFG_RADIAL_K1: r_cfg.k1 <= $signed(i_cfg_data);
                CFG_RADIAL_K2: r_cfg.k2 <= $signed(i_cfg_data);
                CFG_TANG_P1:   r_cfg.p1 <= $signed(i_cfg_data);
                CFG_TANG_P2:   r_cfg.p2 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // valid bits ride alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_s_axis_tvalid};
        end
    end

    // normalize column and row
    ldc_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pix    (i_s_axis_tdata[PIX_W-1:0]),
        .i_center (r_cfg.center_x),
        .i_focal  (r_cfg.focal_x),
        .o_q      (x)
    );

    ldc_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pix    (i_s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_center (r_cfg.center_y),
        .i_focal  (r_cfg.focal_y),
        .o_q      (y)
    );

    // distortion and mapping back to pixels; last stage is the output register
    ldc_poly u_poly (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_cfg      (r_cfg),
        .i_x        (x),
        .i_y        (y),
        .o_col      (col),
        .o_row      (row),
        .o_in_frame (in_frame)
    );

`ifndef SYNTHESIS
    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("outside result carries nonzero coordinates");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        ({21'b0, o_m_axis_tdata[PIX_W-1:0]} < FRAME_COLS &&
         {21'b0, o_m_axis_tdata[2*PIX_W-1:PIX_W]} < FRAME_ROWS))
        else $error("inside result beyond frame");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("pipeline enable mismatch");

    a_rst: assert property (@(posedge i_clk)
        (!$past(i_rst_n) && i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ldc_div.sv @@
// pipelined restoring divider: (pix*4096 - center) * 2^24 / focal, saturated
`default_nettype none

module ldc_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [ldc_pkg::PIX_W-1:0]         i_pix,
    input  wire logic [ldc_pkg::Q12_W-1:0]         i_center,
    input  wire logic [ldc_pkg::Q12_W-1:0]         i_focal,
    output logic signed [ldc_pkg::NORM_W-1:0]      o_q
);
    import ldc_pkg::*;

    logic [Q12_W-1:0] fz;
    logic signed [Q12_W:0] d;
    logic [Q12_W:0] mag;

    logic [Q12_W-1:0]     r_rem [DIV_STEPS+1];
    logic [NORM_W-1:0]    r_q   [DIV_STEPS+1];
    logic [1:0]           r_lo  [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];

    // zero focal length divides as one lsb
    assign fz  = (i_focal == '0) ? Q12_W'(1) : i_focal;
    assign d   = $signed({2'b00, i_pix, 12'b0}) - $signed({1'b0, i_center});
    assign mag = d[Q12_W] ? (Q12_W+1)'(-d) : d;

    // front: sign, magnitude, quotient overflow when |d| >= 4*focal
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= Q12_W'(mag >> 2);
            r_lo[0]  <= mag[1:0];
            r_q[0]   <= '0;
            r_neg[0] <= d[Q12_W];
            r_ovf[0] <= ({1'b0, mag} >= {fz, 2'b00});
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int J = DIV_STEPS - 1 - k;
        logic         nbit;
        logic [Q12_W:0] sh;
        logic         take;

        always_comb begin
            if (J == DIV_STEPS - 1) begin
                nbit = r_lo[k][1];
            end else if (J == DIV_STEPS - 2) begin
                nbit = r_lo[k][0];
            end else begin
                nbit = 1'b0;
            end
            sh   = {r_rem[k], nbit};
            take = (sh >= {1'b0, fz});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= take ? Q12_W'(sh - {1'b0, fz}) : Q12_W'(sh);
                r_q[k+1]   <= {r_q[k][NORM_W-2:0], take};
                r_lo[k+1]  <= r_lo[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    // saturate to [-2^25, 2^25-1], truncation toward zero
    logic [NORM_W-1:0] qm;
    logic signed [NORM_W-1:0] n_q;
    assign qm = r_q[DIV_STEPS];

    always_comb begin
        if (!r_neg[DIV_STEPS]) begin
            if (r_ovf[DIV_STEPS] || qm[NORM_W-1]) begin
                n_q = {1'b0, {(NORM_W-1){1'b1}}};
            end else begin
                n_q = $signed(qm);
            end
        end else begin
            if (r_ovf[DIV_STEPS] || (qm > {1'b1, {(NORM_W-1){1'b0}}})) begin
                n_q = {1'b1, {(NORM_W-1){1'b0}}};
            end else begin
                n_q = $signed(NORM_W'(-qm));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ldc_poly.sv @@
// distortion polynomial, back to pixel units and frame check
`default_nettype none

module ldc_poly (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire ldc_pkg::t_cfg                  i_cfg,
    input  wire logic signed [ldc_pkg::NORM_W-1:0] i_x,
    input  wire logic signed [ldc_pkg::NORM_W-1:0] i_y,
    output logic [ldc_pkg::PIX_W-1:0]           o_col,
    output logic [ldc_pkg::PIX_W-1:0]           o_row,
    output logic                                o_in_frame
);
    import ldc_pkg::*;

    localparam logic signed [35:0] ONE_Q24 = 36'sd16777216;
    localparam logic signed [41:0] COL_LIM = 42'(FRAME_COLS) <<< 12;
    localparam logic signed [41:0] ROW_LIM = 42'(FRAME_ROWS) <<< 12;

    // stage registers
    logic signed [25:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y, r4_x, r4_y, r5_x, r5_y;
    logic signed [27:0] r1_xx, r1_yy, r1_xy;
    logic signed [28:0] r2_r2;
    logic signed [29:0] r2_tx, r2_ty;
    logic signed [29:0] r2_t1x, r3_t1x, r4_t1x, r5_t1x, r6_t1x;
    logic signed [29:0] r2_t2y, r3_t2y, r4_t2y, r5_t2y, r6_t2y;
    logic signed [31:0] r3_t2x, r4_t2x, r5_t2x, r6_t2x;
    logic signed [31:0] r3_t1y, r4_t1y, r5_t1y, r6_t1y;
    logic signed [31:0] r3_r4, r3_k1r2;
    logic signed [35:0] r4_radp, r5_rad;
    logic signed [33:0] r4_k2r4;
    logic signed [37:0] r6_xr, r6_yr;
    logic signed [39:0] r7_xd, r7_yd;
    logic [43:0]        r8_plx, r8_ply;
    logic signed [44:0] r8_phx, r8_phy;
    logic signed [40:0] r9_sx, r9_sy;
    logic signed [41:0] r10_ud, r10_vd;

    // combinational products and sums
    logic signed [51:0] m_xx, m_yy, m_xy;
    logic signed [29:0] e_xx, e_yy;
    logic signed [59:0] m_p1xy, m_p2xy;
    logic signed [57:0] m_r4;
    logic signed [60:0] m_k1r2;
    logic signed [61:0] m_p2tx, m_p1ty;
    logic signed [63:0] m_k2r4;
    logic signed [61:0] m_xr, m_yr;
    logic signed [39:0] e_xr, e_yr;
    logic signed [64:0] e_phx, e_phy, s_x, s_y;
    logic               in_u, in_v;

    always_comb begin
        m_xx   = i_x * i_x;
        m_yy   = i_y * i_y;
        m_xy   = i_x * i_y;
        e_xx   = r1_xx;
        e_yy   = r1_yy;
        m_p1xy = i_cfg.p1 * r1_xy;
        m_p2xy = i_cfg.p2 * r1_xy;
        m_r4   = r2_r2 * r2_r2;
        m_k1r2 = i_cfg.k1 * r2_r2;
        m_p2tx = i_cfg.p2 * r2_tx;
        m_p1ty = i_cfg.p1 * r2_ty;
        m_k2r4 = i_cfg.k2 * r3_r4;
        m_xr   = r5_x * r5_rad;
        m_yr   = r5_y * r5_rad;
        e_xr   = r6_xr;
        e_yr   = r6_yr;
        e_phx  = r8_phx;
        e_phy  = r8_phy;
        s_x    = (e_phx <<< 20) + $signed({21'b0, r8_plx});
        s_y    = (e_phy <<< 20) + $signed({21'b0, r8_ply});
        in_u   = !r10_ud[41] && (r10_ud < COL_LIM);
        in_v   = !r10_vd[41] && (r10_vd < ROW_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // squares and cross term
            r1_x  <= i_x;
            r1_y  <= i_y;
            r1_xx <= m_xx[51:24];
            r1_yy <= m_yy[51:24];
            r1_xy <= m_xy[51:24];
            // r^2 and tangential sums
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_r2  <= 29'(e_xx + e_yy);
            r2_tx  <= (e_xx <<< 1) + e_xx + e_yy;
            r2_ty  <= (e_yy <<< 1) + e_yy + e_xx;
            r2_t1x <= m_p1xy[59:30];
            r2_t2y <= m_p2xy[59:30];
            // r^4, k1 term, tangential products
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_t1x  <= r2_t1x;
            r3_t2y  <= r2_t2y;
            r3_r4   <= m_r4[55:24];
            r3_k1r2 <= 32'($signed(m_k1r2[60:30]));
            r3_t2x  <= m_p2tx[61:30];
            r3_t1y  <= m_p1ty[61:30];
            // k2 term
            r4_x    <= r3_x;
            r4_y    <= r3_y;
            r4_t1x  <= r3_t1x;
            r4_t2y  <= r3_t2y;
            r4_t2x  <= r3_t2x;
            r4_t1y  <= r3_t1y;
            r4_radp <= ONE_Q24 + 36'(r3_k1r2);
            r4_k2r4 <= m_k2r4[63:30];
            // radial factor
            r5_x   <= r4_x;
            r5_y   <= r4_y;
            r5_t1x <= r4_t1x;
            r5_t2y <= r4_t2y;
            r5_t2x <= r4_t2x;
            r5_t1y <= r4_t1y;
            r5_rad <= r4_radp + 36'(r4_k2r4);
            // scale by radial factor
            r6_xr  <= m_xr[61:24];
            r6_yr  <= m_yr[61:24];
            r6_t1x <= r5_t1x;
            r6_t2y <= r5_t2y;
            r6_t2x <= r5_t2x;
            r6_t1y <= r5_t1y;
            // distorted normalized point
            r7_xd <= e_xr + 40'($signed({r6_t1x, 1'b0})) + 40'(r6_t2x);
            r7_yd <= e_yr + 40'(r6_t1y) + 40'($signed({r6_t2y, 1'b0}));
            // focal product split in two halves
            r8_plx <= i_cfg.focal_x * r7_xd[19:0];
            r8_ply <= i_cfg.focal_y * r7_yd[19:0];
            r8_phx <= $signed({1'b0, i_cfg.focal_x}) * $signed(r7_xd[39:20]);
            r8_phy <= $signed({1'b0, i_cfg.focal_y}) * $signed(r7_yd[39:20]);
            // combine halves, back to q12.12
            r9_sx <= s_x[64:24];
            r9_sy <= s_y[64:24];
            // add principal point
            r10_ud <= 42'(r9_sx) + $signed({18'b0, i_cfg.center_x});
            r10_vd <= 42'(r9_sy) + $signed({18'b0, i_cfg.center_y});
            // frame check and truncation
            o_in_frame <= in_u && in_v;
            o_col      <= (in_u && in_v) ? r10_ud[22:12] : '0;
            o_row      <= (in_u && in_v) ? r10_vd[22:12] : '0;
        end
    end

endmodule

`default_nettype wire
